// ===== sv/dcsf_pkg.sv =====
// Shared types, constants and helper functions of the drive command to stepper frame block.
package dcsf_pkg;

   localparam int FRAME_BYTES = 15;
   localparam logic [3:0] POS_FIRST = 4'd0;
   localparam logic [3:0] POS_LAST = 4'(FRAME_BYTES - 1);
   localparam logic [7:0] FRAME_SOF = 8'h3C;
   localparam logic [7:0] FRAME_EOF = 8'h3E;

   localparam logic [3:0] DIR_ROT_POS = 4'hA;
   localparam logic [3:0] DIR_ROT_NEG = 4'h5;

   localparam logic ACTION_MOVE = 1'b0;
   localparam logic ACTION_ROTATE = 1'b1;

   // 2^19 / 100 rounded up; exact floor for dividends up to 25500
   localparam logic [12:0] RECIP_100 = 13'd5243;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_STEPS_PER_CM = 2'd0;
   localparam logic [1:0] REG_STEPS_PER_DEGREE = 2'd1;
   localparam logic [1:0] REG_MIN_SPEED_INDEX = 2'd2;

   localparam logic [10:0] RST_STEPS_PER_CM = 11'd500;
   localparam logic [10:0] RST_STEPS_PER_DEGREE = 11'd180;
   localparam logic [7:0] RST_MIN_SPEED_INDEX = 8'd0;

   typedef struct packed {
      logic              action;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] angle_deg;
      logic [6:0]        speed_percent;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic [10:0] steps_per_cm;
      logic [10:0] steps_per_degree;
      logic [7:0]  min_speed_index;
   } cfg_type;

   // one fully worked out frame, waiting for the serializer
   typedef struct packed {
      logic [15:0] count12;
      logic [15:0] count34;
      logic [7:0]  index12;
      logic [7:0]  index34;
      logic [3:0]  dir;
   } frame_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CLASSIFY,
      F_MUL12,
      F_MUL34,
      F_MULP,
      F_DIV,
      F_PUSH
   } front_state_type;

   // first k >= 1 with (100 >> k) < delay, 255 for zero delay, then floored
   function automatic logic [7:0] speed_index(input logic [6:0] delay,
                                             input logic [7:0] floor_idx);
      logic [7:0] k;
      if (delay == 7'd0) k = 8'd255;
      else if (delay > 7'd50) k = 8'd1;
      else if (delay > 7'd25) k = 8'd2;
      else if (delay > 7'd12) k = 8'd3;
      else if (delay > 7'd6) k = 8'd4;
      else if (delay > 7'd3) k = 8'd5;
      else if (delay > 7'd1) k = 8'd6;
      else k = 8'd7;
      return (k < floor_idx) ? floor_idx : k;
   endfunction

   function automatic logic [15:0] mag17(input logic signed [16:0] v);
      logic signed [16:0] m;
      m = (v < 0) ? -v : v;
      return m[15:0];
   endfunction

endpackage

// ===== sv/drive_command_to_stepper_frame.sv =====
// Top level: drive command in, 15-byte stepper frame out one byte per transaction.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_payload_type (one command)
//   rsp      out        rsp_valid/rsp_stall  rsp_payload_type (one frame byte)
//   csr      in/out     APB-style, pready=1  steps_per_cm, steps_per_degree, min_speed_index
//
// The serializer sends one frame byte per cycle while not stalled and a frame is queued.
// A move runs classify, three multiplies, the bit-serial ratio divider and push; a rotate
// skips the divider, a stop the multiplies; one more command waits in the input buffer.
// A two-entry frame queue lets the front end run on while rsp_stall holds the output.
// Reset is synchronous and clears control state only; no clearing pass is needed.
module drive_command_to_stepper_frame
   import dcsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type        cfg;
   q_status_type   q_status;
   logic           push_valid;
   frame_desc_type push_data;
   frame_desc_type head;
   logic           pop;

   dcsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dcsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   dcsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   dcsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("frame pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("frame popped from an empty queue");

   a_last_is_eof: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_byte) |-> rsp_payload.frame_byte == FRAME_EOF)
      else $error("last byte of a frame is not the closing byte");

endmodule

// ===== sv/dcsf_csr.sv =====
// Configuration registers behind the APB-style port.
module dcsf_csr
   import dcsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[3:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_cm <= RST_STEPS_PER_CM;
         cfg_ff.steps_per_degree <= RST_STEPS_PER_DEGREE;
         cfg_ff.min_speed_index <= RST_MIN_SPEED_INDEX;
      end else if (wr_en) begin
         case (reg_idx)
            REG_STEPS_PER_CM: cfg_ff.steps_per_cm <= csr_pwdata[10:0];
            REG_STEPS_PER_DEGREE: cfg_ff.steps_per_degree <= csr_pwdata[10:0];
            REG_MIN_SPEED_INDEX: cfg_ff.min_speed_index <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STEPS_PER_CM: csr_prdata = {21'd0, cfg_ff.steps_per_cm};
         REG_STEPS_PER_DEGREE: csr_prdata = {21'd0, cfg_ff.steps_per_degree};
         REG_MIN_SPEED_INDEX: csr_prdata = {24'd0, cfg_ff.min_speed_index};
         default: csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== sv/dcsf_front.sv =====
// Command front end: input buffer, octant classification and the frame arithmetic sequencer.
module dcsf_front
   import dcsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  q_status_type    q_status,
   output logic            push_valid,
   output frame_desc_type  push_data
);

   front_state_type state_ff, state_in;

   logic            buf_valid_ff;
   req_payload_type buf_ff;
   logic            buf_take;
   req_payload_type cmd_ff;

   // classification results
   logic        stop_ff, rot_ff, ratio12_ff, apos_ff;
   logic        r12_neg_ff, r34_neg_ff;
   logic [15:0] r12_mag_ff, r34_mag_ff, num_mag_ff, den_mag_ff, amag_ff;

   // arithmetic results
   logic [15:0] c12_ff, c34_ff;
   logic        neg12_ff, neg34_ff;
   logic [7:0]  rot_idx_ff;
   logic [22:0] rem_ff, dsh_ff;
   logic [6:0]  quo_ff;
   logic [2:0]  div_cnt_ff;

   // classification logic
   logic signed [16:0] xs, ys, r12_s, r34_s, num_s, den_s;
   logic [16:0]        ax, ay;
   logic               xge, yge, xle, yle, c1, ratio12_c;

   // shared multiplier
   logic [15:0] mul_a;
   logic [12:0] mul_b;
   logic [28:0] prod;
   logic [6:0]  rot_diff;
   logic [14:0] rot_v;
   logic [15:0] sat_move, sat_rot;
   logic        move_nz;
   logic        div_ge;
   logic [6:0]  delay;
   logic [7:0]  idx_full, idx_ratio;

   assign req_stall = buf_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req_valid && !buf_valid_ff) begin
         buf_valid_ff <= 1'b1;
      end else if (buf_take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !buf_valid_ff) buf_ff <= req_payload;
   end

   // octant selection, first match wins
   always_comb begin
      xs = {cmd_ff.x_pos[15], cmd_ff.x_pos};
      ys = {cmd_ff.y_pos[15], cmd_ff.y_pos};
      ax = (xs < 0) ? 17'(-xs) : 17'(xs);
      ay = (ys < 0) ? 17'(-ys) : 17'(ys);
      xge = xs >= 0;
      yge = ys >= 0;
      xle = xs <= 0;
      yle = ys <= 0;
      c1 = (xge && yge && ay >= ax) ||
           (!(xge && yge) && !(xge && yle) && xle && yle && ay >= ax);
      if (c1) begin
         r34_s = ys; r12_s = ys - xs; num_s = ys - xs; den_s = ys; ratio12_c = 1'b1;
      end else if (xge && yge) begin
         r34_s = xs; r12_s = ys - xs; num_s = xs - ys; den_s = xs; ratio12_c = 1'b1;
      end else if (xge && yle && ay <= ax) begin
         r12_s = -xs; r34_s = xs + ys; num_s = xs + ys; den_s = xs; ratio12_c = 1'b0;
      end else if (xge && yle) begin
         r12_s = ys; r34_s = ys + xs; num_s = ys + xs; den_s = ys; ratio12_c = 1'b0;
      end else if (xle && yle) begin
         r34_s = xs; r12_s = ys - xs; num_s = xs - ys; den_s = xs; ratio12_c = 1'b1;
      end else if (ay <= ax) begin
         r12_s = -xs; r34_s = xs + ys; num_s = xs + ys; den_s = xs; ratio12_c = 1'b0;
      end else begin
         r12_s = ys; r34_s = ys + xs; num_s = ys + xs; den_s = ys; ratio12_c = 1'b0;
      end
   end

   // (25500 - 255p) for p up to 100, else the term clamps to zero
   always_comb begin
      rot_diff = (cmd_ff.speed_percent <= 7'd100) ? 7'(7'd100 - cmd_ff.speed_percent) : 7'd0;
      rot_v = (15'(rot_diff) << 8) - 15'(rot_diff);
   end

   always_comb begin
      case (state_ff)
         F_MUL12: begin
            mul_a = rot_ff ? amag_ff : r12_mag_ff;
            mul_b = rot_ff ? {2'd0, cfg.steps_per_degree} : {2'd0, cfg.steps_per_cm};
         end
         F_MUL34: begin
            mul_a = r34_mag_ff;
            mul_b = {2'd0, cfg.steps_per_cm};
         end
         F_MULP: begin
            mul_a = rot_ff ? {1'b0, rot_v} : num_mag_ff;
            mul_b = rot_ff ? RECIP_100 : {6'd0, cmd_ff.speed_percent};
         end
         default: begin
            mul_a = 16'd0;
            mul_b = 13'd0;
         end
      endcase
      prod = 29'(mul_a) * 29'(mul_b);
      move_nz = prod[28:4] != 25'd0;
      sat_move = (prod[28:20] != 9'd0) ? 16'hFFFF : prod[19:4];
      sat_rot = (prod[28:16] != 13'd0) ? 16'hFFFF : prod[15:0];
      div_ge = rem_ff >= dsh_ff;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (buf_valid_ff) cmd_ff <= buf_ff;
         end
         F_CLASSIFY: begin
            stop_ff <= cmd_ff.speed_percent == 7'd0;
            rot_ff <= cmd_ff.action == ACTION_ROTATE;
            ratio12_ff <= ratio12_c;
            apos_ff <= !cmd_ff.angle_deg[15] && cmd_ff.angle_deg != 16'sd0;
            amag_ff <= mag17({cmd_ff.angle_deg[15], cmd_ff.angle_deg});
            r12_neg_ff <= r12_s < 0;
            r34_neg_ff <= r34_s < 0;
            r12_mag_ff <= mag17(r12_s);
            r34_mag_ff <= mag17(r34_s);
            num_mag_ff <= mag17(num_s);
            den_mag_ff <= mag17(den_s);
         end
         F_MUL12: begin
            c12_ff <= rot_ff ? sat_rot : sat_move;
            neg12_ff <= !rot_ff && r12_neg_ff && move_nz;
         end
         F_MUL34: begin
            c34_ff <= rot_ff ? c12_ff : sat_move;
            neg34_ff <= !rot_ff && r34_neg_ff && move_nz;
         end
         F_MULP: begin
            rot_idx_ff <= (prod[26:19] < cfg.min_speed_index) ?
                          cfg.min_speed_index : prod[26:19];
            rem_ff <= prod[22:0];
            dsh_ff <= {1'b0, den_mag_ff, 6'd0};
            quo_ff <= 7'd0;
            div_cnt_ff <= 3'd6;
         end
         F_DIV: begin
            // restoring division, one quotient bit per cycle
            if (div_ge) rem_ff <= rem_ff - dsh_ff;
            dsh_ff <= dsh_ff >> 1;
            quo_ff <= {quo_ff[5:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 3'd1;
         end
         default: ;
      endcase
   end

   always_comb begin
      delay = (den_mag_ff == 16'd0) ? 7'd0 : quo_ff;
      idx_full = speed_index(cmd_ff.speed_percent, cfg.min_speed_index);
      idx_ratio = speed_index(delay, cfg.min_speed_index);
      if (stop_ff) begin
         push_data = '0;
      end else if (rot_ff) begin
         push_data.count12 = c12_ff;
         push_data.count34 = c12_ff;
         push_data.index12 = rot_idx_ff;
         push_data.index34 = rot_idx_ff;
         push_data.dir = apos_ff ? DIR_ROT_POS : DIR_ROT_NEG;
      end else begin
         push_data.count12 = c12_ff;
         push_data.count34 = c34_ff;
         push_data.index12 = ratio12_ff ? idx_ratio : idx_full;
         push_data.index34 = ratio12_ff ? idx_full : idx_ratio;
         push_data.dir = {neg34_ff, neg34_ff, neg12_ff, neg12_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      buf_take = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (buf_valid_ff) begin
               buf_take = 1'b1;
               state_in = F_CLASSIFY;
            end
         end
         F_CLASSIFY: state_in = (cmd_ff.speed_percent == 7'd0) ? F_PUSH : F_MUL12;
         F_MUL12: state_in = F_MUL34;
         F_MUL34: state_in = F_MULP;
         F_MULP: state_in = rot_ff ? F_PUSH : F_DIV;
         F_DIV: begin
            if (div_cnt_ff == 3'd0) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_status.full) begin
               push_valid = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

endmodule

// ===== sv/dcsf_queue.sv =====
// Two-entry queue of worked-out frames between the front end and the serializer.
module dcsf_queue
   import dcsf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  frame_desc_type push_data,
   input  logic           pop,
   output frame_desc_type head,
   output q_status_type   q_status
);

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff;

   assign head = entry_ff[rd_ptr_ff];
   assign q_status.empty = count_ff == 2'd0;
   assign q_status.full = count_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push_valid) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push_valid && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push_valid) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ===== sv/dcsf_back.sv =====
// Frame serializer: walks the head frame byte by byte into the output register.
module dcsf_back
   import dcsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  frame_desc_type  head,
   input  q_status_type    q_status,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [3:0]      pos_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   logic            load;
   logic [7:0]      byte_sel;

   assign load = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop = load && pos_ff == POS_LAST;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      case (pos_ff)
         POS_FIRST: byte_sel = FRAME_SOF;
         4'd1, 4'd3: byte_sel = head.count12[15:8];
         4'd2, 4'd4: byte_sel = head.count12[7:0];
         4'd5, 4'd7: byte_sel = head.count34[15:8];
         4'd6, 4'd8: byte_sel = head.count34[7:0];
         4'd9, 4'd10: byte_sel = head.index12;
         4'd11, 4'd12: byte_sel = head.index34;
         4'd13: byte_sel = {4'd0, head.dir};
         POS_LAST: byte_sel = FRAME_EOF;
         default: byte_sel = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            pos_ff <= (pos_ff == POS_LAST) ? POS_FIRST : pos_ff + 4'd1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff.frame_byte <= byte_sel;
         rsp_payload_ff.last_byte <= pos_ff == POS_LAST;
      end
   end

endmodule

// ===== tb/sv/drive_command_to_stepper_frame_tb.sv =====
// Testbench for drive_command_to_stepper_frame: predicts each 15-byte frame and checks it.
`timescale 1ns / 1ps

module drive_command_to_stepper_frame_tb;
   import dcsf_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [3:0] DIR_PAIR12_REV = 4'h3;
   localparam logic [3:0] DIR_PAIR34_REV = 4'hC;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   cfg_type               cfg_model = '{RST_STEPS_PER_CM, RST_STEPS_PER_DEGREE,
                                        RST_MIN_SPEED_INDEX};
   rsp_payload_type       frame_bytes_due[$];
   rsp_payload_type       due_byte;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   int                    long_hold_cycles = 0;

   drive_command_to_stepper_frame u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d frame bytes still due", $time, frame_bytes_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (long_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         long_hold_cycles--;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            $display("%0t: unexpected frame byte: expected none, got %02h last %0b",
                     $time, rsp_payload.frame_byte, rsp_payload.last_byte);
            mismatch_count++;
         end else begin
            due_byte = frame_bytes_due.pop_front();
            if (rsp_payload.frame_byte !== due_byte.frame_byte) begin
               $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                        $time, due_byte.frame_byte, rsp_payload.frame_byte);
               mismatch_count++;
            end
            if (rsp_payload.last_byte !== due_byte.last_byte) begin
               $display("%0t: last_byte mismatch: expected %0b, got %0b",
                        $time, due_byte.last_byte, rsp_payload.last_byte);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- frame predictor ----------------

   function automatic longint pair_steps(input longint sixteenths);
      longint m;
      m = (longint'(cfg_model.steps_per_cm) * (sixteenths < 0 ? -sixteenths : sixteenths)) / 16;
      return sixteenths < 0 ? -m : m;
   endfunction

   function automatic logic [15:0] sat16(input longint v);
      longint m;
      m = v < 0 ? -v : v;
      return m > 65535 ? 16'hFFFF : 16'(m);
   endfunction

   function automatic int unsigned ratio_delay(input int unsigned p, input longint num,
                                               input longint den);
      longint d;
      d = den < 0 ? -den : den;
      if (d == 0) return 0;
      return int'((longint'(p) * (num < 0 ? -num : num)) / d);
   endfunction

   function automatic logic [7:0] speed_index_of(input int unsigned delay);
      int unsigned k;
      if (delay == 0) begin
         k = 255;
      end else begin
         k = 1;
         while ((100 >> k) >= delay) k++;
      end
      return (k < cfg_model.min_speed_index) ? cfg_model.min_speed_index : 8'(k);
   endfunction

   task automatic predict_frame(input req_payload_type cmd);
      logic [7:0]      fb [FRAME_BYTES];
      longint          x, y, a, ax, ay, r12, r34, num, den, s12, s34;
      int unsigned     p, d12, d34, spd;
      logic [15:0]     c12, c34;
      logic [7:0]      i12, i34;
      logic [3:0]      dir;
      bit              on12;
      rsp_payload_type b;
      x = longint'($signed(cmd.x_pos));
      y = longint'($signed(cmd.y_pos));
      a = longint'($signed(cmd.angle_deg));
      p = cmd.speed_percent;
      c12 = '0;
      c34 = '0;
      i12 = '0;
      i34 = '0;
      dir = '0;
      if (p != 0 && cmd.action == ACTION_MOVE) begin
         ax = x < 0 ? -x : x;
         ay = y < 0 ? -y : y;
         if ((x >= 0 && y >= 0 && ay >= ax) || (!(x >= 0 && y >= 0) &&
             !(x >= 0 && y <= 0) && x <= 0 && y <= 0 && ay >= ax)) begin
            r34 = y; r12 = y - x; num = y - x; den = y; on12 = 1;
         end else if (x >= 0 && y >= 0) begin
            r34 = x; r12 = y - x; num = x - y; den = x; on12 = 1;
         end else if (x >= 0 && y <= 0 && ay <= ax) begin
            r12 = -x; r34 = x + y; num = x + y; den = x; on12 = 0;
         end else if (x >= 0 && y <= 0) begin
            r12 = y; r34 = y + x; num = y + x; den = y; on12 = 0;
         end else if (x <= 0 && y <= 0) begin
            r34 = x; r12 = y - x; num = x - y; den = x; on12 = 1;
         end else if (ay <= ax) begin
            r12 = -x; r34 = x + y; num = x + y; den = x; on12 = 0;
         end else begin
            r12 = y; r34 = y + x; num = y + x; den = y; on12 = 0;
         end
         if (on12) begin
            d12 = ratio_delay(p, num, den);
            d34 = p;
         end else begin
            d12 = p;
            d34 = ratio_delay(p, num, den);
         end
         s12 = pair_steps(r12);
         s34 = pair_steps(r34);
         if (s12 < 0) dir |= DIR_PAIR12_REV;
         if (s34 < 0) dir |= DIR_PAIR34_REV;
         c12 = sat16(s12);
         c34 = sat16(s34);
         i12 = speed_index_of(d12);
         i34 = speed_index_of(d34);
      end else if (p != 0) begin
         c12 = sat16(longint'(cfg_model.steps_per_degree) * a);
         c34 = c12;
         spd = (p >= 100) ? 0 : (25500 - 255 * p) / 100;
         i12 = (spd < cfg_model.min_speed_index) ? cfg_model.min_speed_index : 8'(spd);
         i34 = i12;
         dir = (a > 0) ? DIR_ROT_POS : DIR_ROT_NEG;
      end
      fb[0] = FRAME_SOF;
      fb[1] = c12[15:8];
      fb[2] = c12[7:0];
      fb[3] = c12[15:8];
      fb[4] = c12[7:0];
      fb[5] = c34[15:8];
      fb[6] = c34[7:0];
      fb[7] = c34[15:8];
      fb[8] = c34[7:0];
      fb[9] = i12;
      fb[10] = i12;
      fb[11] = i34;
      fb[12] = i34;
      fb[13] = {4'h0, dir};
      fb[14] = FRAME_EOF;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         b.frame_byte = fb[k];
         b.last_byte = (k == FRAME_BYTES - 1);
         frame_bytes_due.push_back(b);
      end
   endtask

   // ---------------- drivers ----------------

   task automatic send_command(input req_payload_type cmd);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame(cmd);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({reg_idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (reg_idx)
         REG_STEPS_PER_CM: cfg_model.steps_per_cm = value[10:0];
         REG_STEPS_PER_DEGREE: cfg_model.steps_per_degree = value[10:0];
         REG_MIN_SPEED_INDEX: cfg_model.min_speed_index = value[7:0];
         default: ;
      endcase
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t: register %0d readback: expected %08h, got %08h",
                  $time, reg_idx, value, csr_prdata);
         mismatch_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int spc, input int spd, input int min_idx);
      csr_write(REG_STEPS_PER_CM, 32'(spc));
      csr_write(REG_STEPS_PER_DEGREE, 32'(spd));
      csr_write(REG_MIN_SPEED_INDEX, 32'(min_idx));
   endtask

   function automatic req_payload_type make_cmd(input logic action, input int x, input int y,
                                                input int a, input int p);
      req_payload_type c;
      c.action = action;
      c.x_pos = 16'(x);
      c.y_pos = 16'(y);
      c.angle_deg = 16'(a);
      c.speed_percent = 7'(p);
      return c;
   endfunction

   function automatic int random_coord();
      case ($urandom_range(0, 3))
         0: return int'($signed(16'($urandom)));
         1: return int'($urandom_range(0, 128)) - 64;
         2: return int'($urandom_range(0, 4096)) - 2048;
         default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      endcase
   endfunction

   function automatic req_payload_type random_command();
      int x, y, a, p, r;
      x = random_coord();
      y = random_coord();
      // octant borders: equal magnitudes or one axis zero
      case ($urandom_range(0, 7))
         0: y = x;
         1: y = -x;
         2: x = 0;
         3: y = 0;
         default: ;
      endcase
      if (y < -32768 || y > 32767) y = 32767;
      a = random_coord();
      r = $urandom_range(0, 19);
      if (r == 0) p = 0;
      else if (r == 1) p = $urandom_range(101, 127);
      else p = $urandom_range(1, 100);
      return make_cmd($urandom_range(0, 1) != 0 ? ACTION_ROTATE : ACTION_MOVE, x, y, a, p);
   endfunction

   // ---------------- tests ----------------

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_command(make_cmd(ACTION_MOVE, 3, 10, 0, 60));
      send_command(make_cmd(ACTION_MOVE, 10, 3, 0, 60));
      send_command(make_cmd(ACTION_MOVE, 10, -3, 0, 60));
      send_command(make_cmd(ACTION_MOVE, 3, -10, 0, 60));
      send_command(make_cmd(ACTION_MOVE, -10, -3, 0, 60));
      send_command(make_cmd(ACTION_MOVE, -3, -10, 0, 60));
      send_command(make_cmd(ACTION_MOVE, -10, 3, 0, 60));
      send_command(make_cmd(ACTION_MOVE, -3, 10, 0, 60));
      send_command(make_cmd(ACTION_MOVE, 5, 5, 0, 100));
      send_command(make_cmd(ACTION_MOVE, 0, 0, 0, 40));
      send_command(make_cmd(ACTION_MOVE, 32767, 32767, 0, 1));
      send_command(make_cmd(ACTION_MOVE, -32768, -32768, 0, 100));
      send_command(make_cmd(ACTION_MOVE, -32768, 32767, 0, 127));
      send_command(make_cmd(ACTION_MOVE, 32767, -32768, 0, 110));
      send_command(make_cmd(ACTION_MOVE, 100, 200, 0, 0));
      send_command(make_cmd(ACTION_ROTATE, -5, 7, 32767, 100));
      send_command(make_cmd(ACTION_ROTATE, 0, 0, -32768, 127));
      send_command(make_cmd(ACTION_ROTATE, 0, 0, 0, 50));
      send_command(make_cmd(ACTION_ROTATE, 0, 0, 90, 1));
      send_command(make_cmd(ACTION_ROTATE, 0, 0, -45, 0));
      send_command(make_cmd(ACTION_ROTATE, 0, 0, 1, 101));
      wait_drained();
   endtask

   task automatic test_config_extremes();
      set_config(0, 0, 255);
      for (int i = 0; i < 12; i++) send_command(random_command());
      wait_drained();
      set_config(2000, 2000, 0);
      for (int i = 0; i < 12; i++) send_command(random_command());
      wait_drained();
   endtask

   task automatic run_random_phase(input int idle, input int stall, input int count);
      int min_idx;
      min_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      set_config($urandom_range(0, 2000), $urandom_range(0, 2000), min_idx);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) send_command(random_command());
      wait_drained();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_idle_phases();
      run_random_phase(0, 0, 100);
      run_random_phase(88, 0, 100);
      run_random_phase(0, 88, 100);
      run_random_phase(9, 9, 100);
   endtask

   // receiver holds off long enough that the frame queue fills and req_stall rises
   task automatic test_long_hold();
      set_config(500, 180, 2);
      idle_pct = 0;
      stall_pct = 0;
      long_hold_cycles = 400;
      for (int i = 0; i < 30; i++) send_command(random_command());
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_idle_phases();
      test_long_hold();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
